// ===== design/presence_timer_window_delta_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for presence_timer_window_delta
// Shared implication forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRESENCE_TIMER_WINDOW_DELTA_MACROS_SVH
`define PRESENCE_TIMER_WINDOW_DELTA_MACROS_SVH

// Same-cycle implication
`define PTWD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptwd: same-cycle check failed");

// Next-cycle implication
`define PTWD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptwd: next-cycle check failed");

`endif

// ===== design/ptwd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwd_pkg
// Constants, codes and shared types of the presence timer.
// ----------------------------------------------------------------------------
package ptwd_pkg;

  // Sample ring geometry
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = RING_AW + 1;

  // Field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned GOOD_W    = 12;
  localparam int unsigned ENTRY_W   = TIME_W + DIST_W;
  localparam int unsigned ELAPSED_W = 23;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Fixed values
  localparam logic [DIST_W-1:0] DIST_LIMIT = 16'd4000;
  localparam int unsigned       MS_PER_S   = 1000;
  localparam int unsigned       BEEP_STEP  = 5;

  // Output mode codes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_OVER  = 2'd2;
  localparam logic [1:0] MODE_CELEB = 2'd3;

  // Melody codes
  localparam logic [1:0] MEL_NONE  = 2'd0;
  localparam logic [1:0] MEL_HAPPY = 2'd1;
  localparam logic [1:0] MEL_SAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELEB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MINGOOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OVRBEEP = 3'd6;

  // Commands into the ring
  typedef struct packed {
    logic clear;
    logic push;
    logic walk;
  } ring_cmd_t;

  // Ring walk status
  typedef struct packed {
    logic busy;
    logic hit;
  } ring_stat_t;

endpackage

// ===== design/ptwd_ram.sv =====
// ----------------------------------------------------------------------------
// ptwd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/ptwd_div.sv =====
// ----------------------------------------------------------------------------
// ptwd_div
// Milliseconds to whole seconds by reciprocal multiplication.
// ----------------------------------------------------------------------------
module ptwd_div
  import ptwd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TIME_W-1:0]    dividend_i,
  output logic                 busy_o,
  output logic [ELAPSED_W-1:0] quot_o
);

  // 1000 = 8 * 125: drop three bits, then multiply by ceil(2^36 / 125)
  localparam int unsigned      PRE_SH   = 3;
  localparam int unsigned      Y_W      = TIME_W - PRE_SH;
  localparam int unsigned      RECIP_W  = 30;
  localparam int unsigned      RECIP_SH = 36;
  localparam int unsigned      PROD_W   = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP  = 30'd549755814;

  logic              busy_q;
  logic [Y_W-1:0]    y_q;
  logic [PROD_W-1:0] prod_q;

  // Busy for the cycle between load and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  // Load the scaled dividend, then form the product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      y_q <= dividend_i[TIME_W-1:PRE_SH];
    end
    if (busy_q) begin
      prod_q <= PROD_W'(y_q) * PROD_W'(RECIP);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = prod_q[RECIP_SH +: ELAPSED_W];

endmodule

// ===== design/ptwd_ring.sv =====
// ----------------------------------------------------------------------------
// ptwd_ring
// Timestamped distance ring in RAM: push, clear and newest-first look-back walk.
// ----------------------------------------------------------------------------
module ptwd_ring
  import ptwd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_cmd_t         cmd_i,
  input  logic [TIME_W-1:0] time_i,
  input  logic [GOOD_W-1:0] dist_i,
  input  logic [TIME_W-1:0] target_i,
  output ring_stat_t        stat_o,
  output logic [GOOD_W-1:0] past_o
);

  localparam logic [RING_AW-1:0] LAST_ADDR = RING_AW'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0]  FULL      = FILL_W'(RING_DEPTH);

  logic [RING_AW-1:0] head_q, head_d, head_base;
  logic [FILL_W-1:0]  fill_q, fill_d, fill_base;
  logic [RING_AW-1:0] raddr_q, raddr_d;
  logic [FILL_W-1:0]  wi_q, wi_d;
  logic               pend_q, pend_d;
  logic               busy_q, busy_d;
  logic               hit_q, hit_d;
  logic [GOOD_W-1:0]  past_q, past_d;
  logic [TIME_W-1:0]  target_q;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic               hit_now;
  logic               issue;

  // Push and clear
  always_comb begin
    head_base = cmd_i.clear ? '0 : head_q;
    fill_base = cmd_i.clear ? '0 : fill_q;
    head_d    = head_base;
    fill_d    = fill_base;
    if (cmd_i.push) begin
      head_d = (head_base == LAST_ADDR) ? '0 : head_base + 1'b1;
      fill_d = (fill_base == FULL) ? fill_base : fill_base + 1'b1;
    end
  end

  assign wdata = {time_i, (DIST_W - GOOD_W)'(0), dist_i};

  // Walk newest to oldest, one read issued a cycle
  always_comb begin
    hit_now = pend_q && (rdata[ENTRY_W-1 -: TIME_W] <= target_q);
    issue   = busy_q && (wi_q < fill_q) && !hit_now;
    busy_d  = busy_q;
    hit_d   = hit_q;
    past_d  = past_q;
    raddr_d = raddr_q;
    wi_d    = wi_q;
    pend_d  = 1'b0;
    if (cmd_i.walk) begin
      busy_d  = 1'b1;
      hit_d   = 1'b0;
      wi_d    = '0;
      raddr_d = (head_d == '0) ? LAST_ADDR : head_d - 1'b1;
    end else if (busy_q) begin
      if (hit_now) begin
        hit_d  = 1'b1;
        past_d = rdata[GOOD_W-1:0];
        busy_d = 1'b0;
      end else if (issue) begin
        pend_d  = 1'b1;
        wi_d    = wi_q + 1'b1;
        raddr_d = (raddr_q == '0) ? LAST_ADDR : raddr_q - 1'b1;
      end else if (!pend_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
      wi_q   <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
      hit_q  <= hit_d;
      wi_q   <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    past_q  <= past_d;
    if (cmd_i.walk) begin
      target_q <= target_i;
    end
  end

  ptwd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (head_base),
    .wdata_i (wdata),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  assign stat_o.busy = busy_q;
  assign stat_o.hit  = hit_q;
  assign past_o      = past_q;

endmodule

// ===== design/presence_timer_window_delta.sv =====
// ----------------------------------------------------------------------------
// presence_timer_window_delta
// Presence-triggered countdown timer driven by poll ticks.
// ----------------------------------------------------------------------------
// Usage: each input word is one poll tick (timestamp, optional distance sample,
// cancel flag) on a valid/ready channel; each tick yields exactly one result
// word on the output valid/ready channel. The user writes registers through the
// cfg port (write enable, index, data) while no tick is in flight, unenforced.
// Timing: a result word is offered after the look-back walk and the seconds
// divider beside it are both done. The walk reads one ring entry per cycle
// from the single RAM read port, newest first, and stops at the first entry
// old enough or at the end of the ring fill. One tick is worked on at a time,
// so the next tick is taken only once the result word of the last one has
// been registered.
// Reset: all timers and phase return to idle with default registers, and the
// ring is empty; no clearing pass runs.
// Stall: a finished result waits in the output register; the next tick is
// accepted meanwhile and held before its phase update until the register
// frees up.
// ----------------------------------------------------------------------------
module presence_timer_window_delta
  import ptwd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TIME_W-1:0]       time_ms_i,
  input  logic                    sample_ready_i,
  input  logic [DIST_W-1:0]       sample_mm_i,
  input  logic                    cancel_press_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              mode_o,
  output logic [15:0]             remaining_s_o,
  output logic signed [12:0]      delta_mm_o,
  output logic                    short_beep_o,
  output logic                    long_beep_o,
  output logic [1:0]              melody_o,
  output logic                    mood_sad_o,
  output logic [ELAPSED_W-1:0]    session_s_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_PREP  = 2'd2;
  localparam logic [1:0] S_PHASE = 2'd3;

  localparam int unsigned REM_W = ELAPSED_W + 2;
  localparam int unsigned SEC_W = 17;

  // Configuration
  logic [CFG_W-1:0]  total_q, window_q, celeb_q, mingood_q, warn_q, ovrbeep_q;
  logic [GOOD_W-1:0] trig_q;

  // Persistent state
  logic [1:0]           st_q, st_d;
  logic [GOOD_W-1:0]    good_q;
  logic [1:0]           phase_q;
  logic [TIME_W-1:0]    start_q, last_ob_q, cel_end_q;
  logic [SEC_W-1:0]     last_beep_q;
  logic [ELAPSED_W-1:0] cel_secs_q;
  logic                 sad_q;

  // Per-tick working registers
  logic [TIME_W-1:0]       now_q;
  logic                    sbeep_q;
  logic                    have_q;
  logic signed [12:0]      delta_q;
  logic [ELAPSED_W-1:0]    elap_q;
  logic signed [REM_W-1:0] rem_q;

  // Output register
  logic                 out_valid_q;
  logic [1:0]           mode_q;
  logic [15:0]          rem_out_q;
  logic signed [12:0]   delta_out_q;
  logic                 sbeep_out_q, lbeep_out_q;
  logic [1:0]           mel_out_q;

  logic       in_acc;
  logic       cancel_hit;
  logic       good_ok;
  logic [GOOD_W-1:0] good_new;
  logic       fire;

  ring_cmd_t         ring_cmd;
  ring_stat_t        ring_stat;
  logic [GOOD_W-1:0] ring_past;
  logic              div_busy;
  logic [ELAPSED_W-1:0] div_quot;

  // Phase update results
  logic [1:0]           phase_n;
  logic [TIME_W-1:0]    start_n, last_ob_n, cel_end_n;
  logic [SEC_W-1:0]     last_beep_n;
  logic [ELAPSED_W-1:0] cel_secs_n;
  logic                 sad_n, sbeep_n, lbeep_n, clear_n;
  logic [1:0]           mel_n;
  logic [15:0]          rem_out_n;
  logic signed [12:0]   trig_s;
  logic                 drop, rise;
  logic [15:0]          sec;
  logic [31:0]          q5_prod;
  logic [15:0]          q5, mod5;
  logic                 due;

  assign in_ready_o = (st_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign fire       = (st_q == S_PHASE) && (!out_valid_q || out_ready_i);

  // Front end of a tick: cancel and distance filter
  assign cancel_hit = cancel_press_i && (phase_q != MODE_IDLE);
  assign good_ok    = sample_ready_i && (sample_mm_i != '0) && (sample_mm_i < DIST_LIMIT);
  assign good_new   = good_ok ? sample_mm_i[GOOD_W-1:0] : good_q;

  // Ring commands come from the accept cycle or the phase update
  always_comb begin
    ring_cmd = '0;
    if (in_acc) begin
      ring_cmd.clear = cancel_hit;
      ring_cmd.push  = (good_new != '0);
      ring_cmd.walk  = 1'b1;
    end else if (fire) begin
      ring_cmd.clear = clear_n;
    end
  end

  ptwd_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ring_cmd),
    .time_i   (time_ms_i),
    .dist_i   (good_new),
    .target_i (time_ms_i - TIME_W'(window_q)),
    .stat_o   (ring_stat),
    .past_o   (ring_past)
  );

  ptwd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (time_ms_i - start_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Sequence one tick
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (in_acc) st_d = S_WALK;
      S_WALK:  if (!ring_stat.busy && !div_busy) st_d = S_PREP;
      S_PREP:  st_d = S_PHASE;
      S_PHASE: if (fire) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Phase update
  always_comb begin
    trig_s  = $signed({1'b0, trig_q});
    drop    = have_q && (delta_q <= -trig_s);
    rise    = have_q && (delta_q >= trig_s);
    sec     = rem_q[15:0];
    q5_prod = sec * 16'd52429;
    q5      = 16'(q5_prod[31:18]);
    mod5    = sec - 16'(q5 * 16'(BEEP_STEP));
    due     = (rem_q <= REM_W'(BEEP_STEP)) || (mod5 == '0);

    phase_n     = phase_q;
    start_n     = start_q;
    last_ob_n   = last_ob_q;
    cel_end_n   = cel_end_q;
    last_beep_n = last_beep_q;
    cel_secs_n  = cel_secs_q;
    sad_n       = sad_q;
    sbeep_n     = sbeep_q;
    lbeep_n     = 1'b0;
    clear_n     = 1'b0;
    mel_n       = MEL_NONE;
    rem_out_n   = '0;

    unique case (phase_q)
      MODE_IDLE: begin
        if (drop) begin
          phase_n     = MODE_RUN;
          start_n     = now_q;
          last_beep_n = '1;
          sbeep_n     = 1'b1;
          clear_n     = 1'b1;
          rem_out_n   = total_q;
        end
      end
      MODE_RUN: begin
        if (rem_q <= 0) begin
          phase_n = MODE_OVER;
        end else begin
          rem_out_n = sec;
          if (rem_q < $signed(REM_W'(warn_q)) && due && ({1'b0, sec} != last_beep_q)) begin
            sbeep_n     = 1'b1;
            last_beep_n = {1'b0, sec};
          end
          if (rise) begin
            clear_n   = 1'b1;
            rem_out_n = '0;
            if (elap_q >= ELAPSED_W'(mingood_q)) begin
              sad_n      = 1'b0;
              cel_secs_n = elap_q;
              cel_end_n  = now_q + TIME_W'(celeb_q);
              phase_n    = MODE_CELEB;
              mel_n      = MEL_HAPPY;
            end else begin
              phase_n = MODE_IDLE;
            end
          end
        end
      end
      MODE_OVER: begin
        if ((now_q - last_ob_q) > TIME_W'(ovrbeep_q)) begin
          lbeep_n   = 1'b1;
          last_ob_n = now_q;
        end
        if (rise) begin
          clear_n    = 1'b1;
          sad_n      = 1'b1;
          cel_secs_n = elap_q;
          cel_end_n  = now_q + TIME_W'(celeb_q);
          phase_n    = MODE_CELEB;
          mel_n      = MEL_SAD;
        end
      end
      MODE_CELEB: begin
        if (now_q >= cel_end_q) begin
          phase_n = MODE_IDLE;
        end
      end
      default: phase_n = MODE_IDLE;
    endcase
  end

  // Control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      total_q     <= 16'd240;
      trig_q      <= 12'd400;
      window_q    <= 16'd1000;
      celeb_q     <= 16'd6000;
      mingood_q   <= 16'd60;
      warn_q      <= 16'd30;
      ovrbeep_q   <= 16'd700;
      good_q      <= '0;
      phase_q     <= MODE_IDLE;
      start_q     <= '0;
      last_beep_q <= '1;
      last_ob_q   <= '0;
      cel_end_q   <= '0;
      cel_secs_q  <= '0;
      sad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      // Write configuration
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL:   total_q   <= cfg_data_i;
          CFG_TRIGGER: trig_q    <= cfg_data_i[GOOD_W-1:0];
          CFG_WINDOW:  window_q  <= cfg_data_i;
          CFG_CELEB:   celeb_q   <= cfg_data_i;
          CFG_MINGOOD: mingood_q <= cfg_data_i;
          CFG_WARN:    warn_q    <= cfg_data_i;
          CFG_OVRBEEP: ovrbeep_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Apply cancel and distance at accept
      if (in_acc) begin
        good_q <= good_new;
        if (cancel_hit) begin
          phase_q <= MODE_IDLE;
        end
      end else if (fire) begin
        phase_q     <= phase_n;
        start_q     <= start_n;
        last_beep_q <= last_beep_n;
        last_ob_q   <= last_ob_n;
        cel_end_q   <= cel_end_n;
        cel_secs_q  <= cel_secs_n;
        sad_q       <= sad_n;
      end
      // Hold the output word until taken
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q   <= time_ms_i;
      sbeep_q <= cancel_hit;
    end
    if (st_q == S_PREP - 2'd1 && st_d == S_PREP) begin
      have_q  <= ring_stat.hit;
      delta_q <= ring_stat.hit ?
                 $signed({1'b0, good_q}) - $signed({1'b0, ring_past}) : '0;
      elap_q  <= div_quot;
      rem_q   <= $signed(REM_W'(total_q)) - $signed(REM_W'(div_quot));
    end
    if (fire) begin
      mode_q      <= phase_n;
      rem_out_q   <= (phase_n == MODE_RUN) ? rem_out_n : '0;
      delta_out_q <= delta_q;
      sbeep_out_q <= sbeep_n;
      lbeep_out_q <= lbeep_n;
      mel_out_q   <= mel_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mode_o        = mode_q;
  assign remaining_s_o = rem_out_q;
  assign delta_mm_o    = delta_out_q;
  assign short_beep_o  = sbeep_out_q;
  assign long_beep_o   = lbeep_out_q;
  assign melody_o      = mel_out_q;
  assign mood_sad_o    = sad_q;
  assign session_s_o   = cel_secs_q;

endmodule

// ===== design/ptwd_checker.sv =====
// ----------------------------------------------------------------------------
// ptwd_checker
// Port-level checks on result words of the presence timer, bound to the top.
// ----------------------------------------------------------------------------
`include "presence_timer_window_delta_macros.svh"

module ptwd_checker
  import ptwd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  mode_o,
  input logic [15:0] remaining_s_o,
  input logic        long_beep_o,
  input logic [1:0]  melody_o,
  input logic        mood_sad_o
);

  // Remaining time only shows while running
  `PTWD_ASSERT_IMP(a_rem_run_only, out_valid_o && (mode_o != MODE_RUN), remaining_s_o == '0)

  // A melody starts only on entry to celebrate
  `PTWD_ASSERT_IMP(a_melody_celeb, out_valid_o && (melody_o != MEL_NONE), mode_o == MODE_CELEB)

  // Sad melody goes with sad mood
  `PTWD_ASSERT_IMP(a_sad_mood, out_valid_o && (melody_o == MEL_SAD), mood_sad_o)

  // Long beeps only come from overrun
  `PTWD_ASSERT_IMP(a_long_beep_mode, out_valid_o && long_beep_o, (mode_o == MODE_OVER) || (mode_o == MODE_CELEB))

  // A stalled word stays offered
  `PTWD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind presence_timer_window_delta ptwd_checker u_ptwd_checker (.*);
